/* rtl/asa_pkg.sv */
// ----------------------------------------------------------------------------
// asa_pkg: shared types and constants of the steering angle unit
// Datapath widths, the CORDIC arctangent table and the degree scale factor.
// ----------------------------------------------------------------------------
package asa_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int LANES            = 2;

    localparam int RADIUS_W = 24;
    localparam int REG_W    = 16;
    localparam int NUM_W    = REG_W + 1;      // 2 * wheelbase
    localparam int DEN_W    = RADIUS_W + 2;   // 2 * radius +/- track, signed
    localparam int MAG_W    = DEN_W - 1;      // |denominator|
    localparam int FRAC_W   = 20;
    localparam int XY_W     = 48;             // CORDIC x / y, signed
    localparam int Z_W      = 26;             // angle at 2^-24 rad, signed
    localparam int ZMAG_W   = Z_W - 1;
    localparam int ANG_W    = 11;             // tenths of a degree, signed
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    localparam logic [REG_W-1:0] WHEELBASE_RST = 16'd1400;
    localparam logic [REG_W-1:0] TRACK_RST     = 16'd1200;

    // register indexes on the configuration port
    localparam logic REG_WHEELBASE = 1'b0;
    localparam logic REG_TRACK     = 1'b1;

    // round(1800/pi * 2^24), split for two narrow multipliers
    localparam int K_W    = 34;
    localparam int KLO_W  = 17;
    localparam int KHI_W  = K_W - KLO_W;
    localparam logic [K_W-1:0]   TENTHS_K = 34'd9612636688;
    localparam logic [KHI_W-1:0] K_HI     = TENTHS_K[K_W-1:KLO_W];
    localparam logic [KLO_W-1:0] K_LO     = TENTHS_K[KLO_W-1:0];
    localparam int PROD_W       = ZMAG_W + K_W;
    localparam int TENTHS_SHIFT = 48;

    localparam logic [ANG_W-1:0] ANGLE_MAX = 11'd900;

    typedef struct packed {
        logic force_zero;   // straight command, or zero wheelbase with a nonzero denominator
        logic force_max;    // zero denominator: +90 degrees
        logic neg;          // denominator below zero
    } t_meta;

    // atan(2^-i) at 2^-24 rad, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 26'sd13176795;
            1:       v = 26'sd7778716;
            2:       v = 26'sd4110060;
            3:       v = 26'sd2086331;
            4:       v = 26'sd1047214;
            5:       v = 26'sd524117;
            6:       v = 26'sd262123;
            7:       v = 26'sd131069;
            8:       v = 26'sd65536;
            9:       v = 26'sd32768;
            10:      v = 26'sd16384;
            11:      v = 26'sd8192;
            12:      v = 26'sd4096;
            13:      v = 26'sd2048;
            14:      v = 26'sd1024;
            15:      v = 26'sd512;
            16:      v = 26'sd256;
            17:      v = 26'sd128;
            18:      v = 26'sd64;
            19:      v = 26'sd32;
            20:      v = 26'sd16;
            21:      v = 26'sd8;
            22:      v = 26'sd4;
            23:      v = 26'sd2;
            24:      v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/asa_cordic_cell.sv */
// ----------------------------------------------------------------------------
// asa_cordic_cell: one vectoring step of the arctangent chain
// Rotates (x, y) toward the x axis by atan(2^-IDX) and hands it on.
// ----------------------------------------------------------------------------
module asa_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [asa_pkg::XY_W-1:0]   i_x,
    input  logic signed [asa_pkg::XY_W-1:0]   i_y,
    input  logic signed [asa_pkg::Z_W-1:0]    i_z,
    input  asa_pkg::t_meta                    i_meta,
    output logic signed [asa_pkg::XY_W-1:0]   o_x,
    output logic signed [asa_pkg::XY_W-1:0]   o_y,
    output logic signed [asa_pkg::Z_W-1:0]    o_z,
    output asa_pkg::t_meta                    o_meta
);
    import asa_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN_C = atan_entry(IDX);

    logic signed [XY_W-1:0] w_dx;
    logic signed [XY_W-1:0] w_dy;
    logic signed [XY_W-1:0] r_x, n_x;
    logic signed [XY_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    t_meta                  r_meta;

    // arithmetic shift rounds toward minus infinity
    assign w_dx = i_y >>> IDX;
    assign w_dy = i_x >>> IDX;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN_C;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_meta <= i_meta;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_meta = r_meta;

endmodule

/* rtl/asa_scale.sv */
// ----------------------------------------------------------------------------
// asa_scale: radians to tenths of a degree
// Two stages: split multiply by the scale factor, then shift, clamp, sign or force.
// ----------------------------------------------------------------------------
module asa_scale (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [asa_pkg::Z_W-1:0]    i_z,
    input  asa_pkg::t_meta                    i_meta,
    output logic signed [asa_pkg::ANG_W-1:0]  o_angle
);
    import asa_pkg::*;

    logic [ZMAG_W-1:0]       w_mag;
    logic [ZMAG_W+KHI_W-1:0] r_p_hi;
    logic [ZMAG_W+KLO_W-1:0] r_p_lo;
    t_meta                   r_meta;
    logic [PROD_W-1:0]       w_prod;
    logic [ANG_W-1:0]        w_t;
    logic [ANG_W-1:0]        w_clamped;
    logic signed [ANG_W-1:0] n_angle;
    logic signed [ANG_W-1:0] r_angle;

    // negative angle magnitude clamps to zero
    assign w_mag = i_z[Z_W-1] ? '0 : i_z[ZMAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_hi <= w_mag * K_HI;
            r_p_lo <= w_mag * K_LO;
            r_meta <= i_meta;
        end
    end

    assign w_prod    = {r_p_hi, {KLO_W{1'b0}}} + PROD_W'(r_p_lo);
    assign w_t       = w_prod[TENTHS_SHIFT +: ANG_W];
    assign w_clamped = (w_t > ANGLE_MAX) ? ANGLE_MAX : w_t;

    always_comb begin
        priority if (r_meta.force_zero) begin
            n_angle = '0;
        end else if (r_meta.force_max) begin
            n_angle = $signed(ANGLE_MAX);
        end else if (r_meta.neg) begin
            n_angle = -$signed(w_clamped);
        end else begin
            n_angle = $signed(w_clamped);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* rtl/ackermann_steering_angles_unit.sv */
// ----------------------------------------------------------------------------
// ackermann_steering_angles_unit: front wheel angles of an Ackermann vehicle
// Turns a straight/turn command into left and right wheel angles.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one word per command. tuser is the straight flag; tdata
//   holds the signed turn radius in mm. A straight word yields two zero
//   angles; a turn word yields atan(2*wheelbase / (2*radius -/+ track)) for
//   the left / right wheel in tenths of a degree, truncated toward zero.
//   Master channel: one word per command, left angle in the low 11 bits,
//   right angle in the next 11 bits.
//   Configuration: write wheelbase (index 0) or track (index 1) on the plain
//   write port while no command is in flight.
//   Throughput: one command per cycle while the master side takes results.
//   Pipe: prep stage, one cell per arctangent step, two scaling stages.
//   Stall: the whole pipe holds while a result waits on the master side; a
//   one-word skid register still takes the next command, then tready drops.
//   Reset: clears all valid flags and the skid, loads wheelbase 1400 mm and
//   track 1200 mm. Both wheel lanes run side by side in two cell rows.
// ----------------------------------------------------------------------------
module ackermann_steering_angles_unit #(
    parameter int CORDIC_STEPS = asa_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_addr,
    input  logic [asa_pkg::REG_W-1:0]           i_cfg_wdata,
    // command stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [asa_pkg::TDATA_IN_W-1:0]      i_s_tdata,   // [23:0] turn_radius_mm
    input  logic                                i_s_tuser,   // [0] is_straight
    // angle stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [asa_pkg::TDATA_OUT_W-1:0]     o_m_tdata    // [10:0] left, [21:11] right
);
    import asa_pkg::*;

    localparam int LAT = CORDIC_STEPS + 3;

    // configuration registers
    logic [REG_W-1:0] r_wheelbase;
    logic [REG_W-1:0] r_track;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase <= WHEELBASE_RST;
            r_track     <= TRACK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WHEELBASE: r_wheelbase <= i_cfg_wdata;
                REG_TRACK:     r_track     <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // pipe advance and input skid
    logic                       w_en;
    logic                       r_skid_vld;
    logic                       r_skid_straight;
    logic [RADIUS_W-1:0]        r_skid_radius;
    logic                       w_in_acc;
    logic                       w_src_vld;
    logic                       w_src_straight;
    logic [RADIUS_W-1:0]        w_src_radius;
    logic [LAT-1:0]             r_vld;

    assign w_en       = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = !r_skid_vld;
    assign w_in_acc   = i_s_tvalid && !r_skid_vld;

    // drain the skid first, otherwise take the live word
    assign w_src_vld      = r_skid_vld || w_in_acc;
    assign w_src_straight = r_skid_vld ? r_skid_straight : i_s_tuser;
    assign w_src_radius   = r_skid_vld ? r_skid_radius : i_s_tdata[RADIUS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (w_en) begin
                r_skid_vld <= 1'b0;
                r_vld      <= {r_vld[LAT-2:0], w_src_vld};
            end else if (w_in_acc) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_acc) begin
            r_skid_straight <= i_s_tuser;
            r_skid_radius   <= i_s_tdata[RADIUS_W-1:0];
        end
    end

    // prep stage: both denominators, CORDIC start vectors, special cases
    logic signed [DEN_W-1:0] w_two_r;
    logic signed [DEN_W-1:0] w_trk;
    logic [NUM_W-1:0]        w_num;
    logic signed [DEN_W-1:0] w_den  [LANES];
    logic [MAG_W-1:0]        w_dmag [LANES];
    t_meta                   w_meta [LANES];

    logic signed [XY_W-1:0]  w_x    [LANES][CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  w_y    [LANES][CORDIC_STEPS+1];
    logic signed [Z_W-1:0]   w_z    [LANES][CORDIC_STEPS+1];
    t_meta                   w_mt   [LANES][CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] w_ang  [LANES];

    assign w_two_r = $signed({w_src_radius[RADIUS_W-1], w_src_radius, 1'b0});
    assign w_trk   = $signed({{(DEN_W-REG_W){1'b0}}, r_track});
    assign w_num   = {r_wheelbase, 1'b0};
    assign w_den[0] = w_two_r - w_trk;   // left wheel
    assign w_den[1] = w_two_r + w_trk;   // right wheel

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [XY_W-1:0] r_x0;
        logic signed [XY_W-1:0] r_y0;
        t_meta                  r_meta0;

        assign w_dmag[l] = w_den[l][DEN_W-1] ? MAG_W'(-w_den[l]) : MAG_W'(w_den[l]);

        always_comb begin
            w_meta[l].neg        = w_den[l][DEN_W-1];
            w_meta[l].force_max  = !w_src_straight && (w_den[l] == '0);
            w_meta[l].force_zero = w_src_straight || (w_den[l] != '0 && w_num == '0);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x0    <= $signed({{(XY_W-MAG_W-FRAC_W){1'b0}}, w_dmag[l], {FRAC_W{1'b0}}});
                r_y0    <= $signed({{(XY_W-NUM_W-FRAC_W){1'b0}}, w_num, {FRAC_W{1'b0}}});
                r_meta0 <= w_meta[l];
            end
        end

        assign w_x[l][0]  = r_x0;
        assign w_y[l][0]  = r_y0;
        assign w_z[l][0]  = '0;
        assign w_mt[l][0] = r_meta0;

        // row of arctangent cells, one step each
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
            asa_cordic_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_x    (w_x[l][k]),
                .i_y    (w_y[l][k]),
                .i_z    (w_z[l][k]),
                .i_meta (w_mt[l][k]),
                .o_x    (w_x[l][k+1]),
                .o_y    (w_y[l][k+1]),
                .o_z    (w_z[l][k+1]),
                .o_meta (w_mt[l][k+1])
            );
        end

        asa_scale u_scale (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_z     (w_z[l][CORDIC_STEPS]),
            .i_meta  (w_mt[l][CORDIC_STEPS]),
            .o_angle (w_ang[l])
        );
    end

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = {{(TDATA_OUT_W-2*ANG_W){1'b0}}, w_ang[1], w_ang[0]};

endmodule

/* dv/ackermann_steering_angles_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ackermann_steering_angles_unit_test: self-checking bench of the angle unit
// Streams straight and turn commands under random gaps and back-pressure,
// predicts both wheel angles with a bit-exact CORDIC of its own and checks
// every word on the angle stream against the oldest prediction, in order.
// ----------------------------------------------------------------------------
module ackermann_steering_angles_unit_test;

    import asa_pkg::*;

    // pipe depth of the block: prep stage, one cell per step, two scale stages
    localparam int STEPS        = CORDIC_STEPS_DEF;
    localparam int LATENCY      = STEPS + 3;
    localparam int STALL_LIMIT  = 2000;      // cycles without any handshake
    localparam int FRAC_BITS    = 20;
    localparam int SCALE_SHIFT  = 48;
    localparam longint DEG_TENTHS_SCALE = 64'd9612636688;   // 1800/pi at 2^24
    localparam int RANDOM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE   = 225;

    typedef struct packed {
        logic [ANG_W-1:0] right;
        logic [ANG_W-1:0] left;
    } t_angle_pair;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic                    i_cfg_addr;
    logic [REG_W-1:0]        i_cfg_wdata;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [TDATA_IN_W-1:0]   i_s_tdata;    // [23:0] turn_radius_mm
    logic                    i_s_tuser;    // [0] is_straight
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [TDATA_OUT_W-1:0]  o_m_tdata;    // [10:0] left, [21:11] right

    // bench copy of the geometry registers
    logic [REG_W-1:0] wheelbase_cfg;
    logic [REG_W-1:0] track_cfg;

    t_angle_pair pending_angles[$];
    int          error_count;
    int          quiet_cycles;
    bit          steady_source;     // no gaps on the command side
    bit          steady_sink;       // no stalls on the angle side

    ackermann_steering_angles_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // atan(2^-i) in radians at 2^-24, rounded to nearest
    function automatic longint arctan_step(int i);
        case (i)
            0:       return 13176795;
            1:       return 7778716;
            2:       return 4110060;
            3:       return 2086331;
            4:       return 1047214;
            5:       return 524117;
            6:       return 262123;
            7:       return 131069;
            8:       return 65536;
            9:       return 32768;
            10:      return 16384;
            11:      return 8192;
            12:      return 4096;
            13:      return 2048;
            14:      return 1024;
            15:      return 512;
            16:      return 256;
            17:      return 128;
            18:      return 64;
            19:      return 32;
            20:      return 16;
            21:      return 8;
            22:      return 4;
            23:      return 2;
            24:      return 1;
            default: return 0;
        endcase
    endfunction

    // atan(num / den) in tenths of a degree, truncated toward zero; num >= 0
    function automatic logic [ANG_W-1:0] wheel_angle_tenths(longint num, longint den);
        longint x, y, z, dx, dy, mag, tenths;
        int     steps;
        if (den == 0)
            return ANGLE_MAX;       // quarter turn, even with no wheelbase
        if (num == 0)
            return '0;
        x = (den < 0 ? -den : den) <<< FRAC_BITS;
        y = num <<< FRAC_BITS;
        z = 0;
        steps = STEPS;
        if (steps < 1)
            steps = 1;
        if (steps > 32)
            steps = 32;
        for (int i = 0; i < steps; i++) begin
            // arithmetic shifts floor toward minus infinity
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_step(i);
            end
        end
        mag = (z < 0) ? 0 : z;
        tenths = (mag * DEG_TENTHS_SCALE) >>> SCALE_SHIFT;
        if (tenths > 900)
            tenths = 900;
        if (den < 0)
            tenths = -tenths;
        return tenths[ANG_W-1:0];
    endfunction

    function automatic t_angle_pair predict_angles(logic straight, logic [RADIUS_W-1:0] radius);
        t_angle_pair pair;
        longint      r, num, trk;
        pair = '0;
        if (!straight) begin
            r   = {{(64-RADIUS_W){radius[RADIUS_W-1]}}, radius};
            num = 2 * longint'(wheelbase_cfg);
            trk = longint'(track_cfg);
            pair.left  = wheel_angle_tenths(num, 2 * r - trk);
            pair.right = wheel_angle_tenths(num, 2 * r + trk);
        end
        return pair;
    endfunction

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // offer one command word and hold it until the block takes it
    task automatic send_command(logic straight, logic [RADIUS_W-1:0] radius);
        int gap;
        gap = steady_source ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = straight;
        i_s_tdata  = radius;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1)
            @(posedge i_clk);
        pending_angles.push_back(predict_angles(straight, radius));
        @(negedge i_clk);
    endtask

    // drop valid, let every outstanding word drain, then let the pipe empty
    task automatic drain_pipe();
        i_s_tvalid = 1'b0;
        while (pending_angles.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // registers change only with the pipe empty
    task automatic write_register(logic index, logic [REG_W-1:0] value);
        drain_pipe();
        i_cfg_we    = 1'b1;
        i_cfg_addr  = index;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == REG_WHEELBASE)
            wheelbase_cfg = value;
        else
            track_cfg = value;
    endtask

    task automatic set_geometry(logic [REG_W-1:0] wheelbase, logic [REG_W-1:0] track);
        write_register(REG_WHEELBASE, wheelbase);
        write_register(REG_TRACK, track);
    endtask

    // mix of radii: near the zero-denominator points, tight turns, anything,
    // and the ends of the 24-bit range
    function automatic logic [RADIUS_W-1:0] pick_radius();
        int sel, half, span, r;
        sel  = $urandom_range(0, 99);
        half = int'(track_cfg) >>> 1;
        span = 4 * int'(wheelbase_cfg) + 16;
        if (sel < 30)
            r = ($urandom_range(0, 1) ? half : -half) + int'($urandom_range(0, 8)) - 4;
        else if (sel < 60)
            r = int'($urandom_range(0, 2 * span)) - span;
        else if (sel < 90)
            r = int'($urandom);
        else if ($urandom_range(0, 1))
            r = 32'h007F_FFFF - int'($urandom_range(0, 3));
        else
            r = 32'hFF80_0000 + int'($urandom_range(0, 3));
        return r[RADIUS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Angle side: random stalls, in-order check against the predictions
    // ------------------------------------------------------------------
    initial begin : angle_checker
        t_angle_pair want;
        t_angle_pair got;
        int          stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady_sink ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            @(posedge i_clk);
            while (o_m_tvalid !== 1'b1)
                @(posedge i_clk);
            got = o_m_tdata[2*ANG_W-1:0];
            if (pending_angles.size() == 0) begin
                $display("%0t: angle word with no command outstanding: %h", $time, got);
                error_count++;
            end else begin
                want = pending_angles.pop_front();
                if (got.left !== want.left) begin
                    $display("%0t: left angle mismatch: expected %0d, actual %0d",
                             $time, $signed(want.left), $signed(got.left));
                    error_count++;
                end
                if (got.right !== want.right) begin
                    $display("%0t: right angle mismatch: expected %0d, actual %0d",
                             $time, $signed(want.right), $signed(got.right));
                    error_count++;
                end
            end
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run that stops moving words is a failure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // straight commands ignore the radius entirely
    task automatic test_straight();
        send_command(1'b1, 24'h000000);
        send_command(1'b1, 24'h7FFFFF);
        send_command(1'b1, 24'h800000);
    endtask

    // radius at zero, unit and full-scale values with reset geometry
    task automatic test_radius_extremes();
        send_command(1'b0, 24'h000000);
        send_command(1'b0, 24'h000001);
        send_command(1'b0, 24'hFFFFFF);
        send_command(1'b0, 24'h7FFFFF);
        send_command(1'b0, 24'h800000);
    endtask

    // radius equal to half the track puts one wheel's denominator at zero
    task automatic test_zero_denominator();
        send_command(1'b0, 24'(int'(track_cfg) >>> 1));
        send_command(1'b0, 24'(-(int'(track_cfg) >>> 1)));
    endtask

    // widest, empty and minimal geometry
    task automatic test_geometry_extremes();
        set_geometry(16'hFFFF, 16'hFFFF);
        send_command(1'b0, 24'h000000);
        send_command(1'b0, 24'd32767);
        send_command(1'b0, 24'd32768);
        send_command(1'b0, 24'(-32768));
        // no wheelbase: zero angle unless the denominator is zero too
        set_geometry(16'h0000, 16'h0000);
        send_command(1'b0, 24'h000000);
        send_command(1'b0, 24'd5);
        set_geometry(16'h0001, 16'h0000);
        send_command(1'b0, 24'h000001);
        send_command(1'b0, 24'hFFFFFF);
        send_command(1'b0, 24'h7FFFFF);
    endtask

    // random commands over several geometries, with bursts and a drain pause
    task automatic test_random_turns();
        logic [REG_W-1:0] wb, trk;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       begin wb = WHEELBASE_RST; trk = TRACK_RST; end
                1:       begin wb = 16'd1;         trk = 16'd0;     end
                2:       begin wb = 16'hFFFF;      trk = 16'hFFFF;  end
                3:       begin wb = 16'($urandom_range(1, 200));
                               trk = 16'($urandom_range(0, 250) * 2 + 1); end
                default: begin wb = 16'($urandom_range(1, 65535));
                               trk = 16'($urandom_range(0, 65535)); end
            endcase
            set_geometry(wb, trk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // reshuffle the idling pattern now and then
                if (n % 40 == 0) begin
                    steady_source = ($urandom_range(0, 3) == 0);
                    steady_sink   = ($urandom_range(0, 3) == 0);
                end
                // hold the source until every angle is back
                if (n == ITEMS_PER_PHASE / 2)
                    drain_pipe();
                send_command(($urandom_range(0, 99) < 8), pick_radius());
            end
        end
        steady_source = 1'b0;
        steady_sink   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_WHEELBASE;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = 1'b0;
        wheelbase_cfg = WHEELBASE_RST;
        track_cfg     = TRACK_RST;
        error_count   = 0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_straight();
        test_radius_extremes();
        test_zero_denominator();
        test_geometry_extremes();
        test_random_turns();

        // drain, then give stray words time to show up
        drain_pipe();
        repeat (LATENCY + 8) @(negedge i_clk);
        if (pending_angles.size() != 0) begin
            $display("%0t: %0d angle words never arrived", $time, pending_angles.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
